/* rtl/core/csv_field_tokenizer_macros.svh */
// ---------------------------------------------------------------------------
// csv_field_tokenizer assertion macros
// shared assertion forms for the tokenizer checkers
// ---------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// assertion clocked on i_clk, quiet while i_rst_n is low
`define CSVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion clocked on i_clk, also checked during reset
`define CSVT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/csvt_pkg.sv */
// ---------------------------------------------------------------------------
// csvt_pkg
// types and constants shared by the csv field tokenizer
// ---------------------------------------------------------------------------
package csvt_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // most result beats one input byte can cause
    localparam int TOK_MAX = 4;
    localparam int TOK_IW  = $clog2(TOK_MAX);
    localparam int TOK_CW  = $clog2(TOK_MAX + 1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOF  = 2'd1,
        KIND_EOR  = 2'd2
    } t_kind;

    // parse state, one-hot
    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,
        MODE_PLAIN  = 4'b0010,
        MODE_QUOTED = 4'b0100,
        MODE_QSEEN  = 4'b1000
    } t_mode;

    // one classified byte: its list of result beats
    typedef struct packed {
        logic [TOK_IW-1:0]  last_idx;
        t_kind [TOK_MAX-1:0] kinds;
        logic [7:0]         value;
    } t_work;

    // front to queue
    typedef struct packed {
        logic  valid;
        t_work work;
    } t_push;

    // queue head to back
    typedef struct packed {
        logic  valid;
        t_work work;
    } t_head;

endpackage

/* rtl/core/csvt_ifs.sv */
// ---------------------------------------------------------------------------
// csvt channel interfaces
// valid/ready channels for input bytes, result beats and configuration
// ---------------------------------------------------------------------------

// input byte channel
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// result beat channel
interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last_of_run;

    modport source (output valid, output kind, output value, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input value, input last_of_run,
                    output ready);
endinterface

// delimiter write channel
interface csvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] delimiter;

    modport source (output valid, output delimiter, input ready);
    modport sink   (input valid, input delimiter, output ready);
endinterface

/* rtl/core/csvt_front.sv */
// ---------------------------------------------------------------------------
// csvt_front
// accepts bytes, runs the parse state and builds each byte's beat list
// ---------------------------------------------------------------------------
module csvt_front import csvt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    csvt_in_if.sink        i_in,
    csvt_cfg_if.sink       i_cfg,
    input  logic           i_q_ready,
    output t_push          o_push
);

    logic [7:0]        r_delim;
    t_mode             r_mode, n_mode;
    logic              r_par, n_par;
    logic              r_lhb, n_lhb;

    logic [7:0]        w_byte;
    logic [7:0]        w_delim;
    logic              w_is_quote;
    logic              w_is_brk;
    logic              w_accept;
    logic [TOK_CW-1:0] w_cnt;
    logic [TOK_CW-1:0] w_last;
    t_kind [TOK_MAX-1:0] w_kinds;

    assign w_byte     = i_in.data_byte;
    assign w_is_quote = (w_byte == CH_QUOTE);
    assign w_is_brk   = (w_byte == CH_CR) || (w_byte == CH_LF);

    // unusable delimiter codes fall back to comma
    always_comb begin
        if (r_delim == 8'd0 || r_delim == CH_QUOTE || r_delim == CH_CR || r_delim == CH_LF) begin
            w_delim = CH_COMMA;
        end else begin
            w_delim = r_delim;
        end
    end

    // parse step and beat list
    always_comb begin
        n_mode = r_mode;
        n_par  = r_par;
        n_lhb  = r_lhb;
        w_cnt  = '0;
        for (int i = 0; i < TOK_MAX; i++) begin
            w_kinds[i] = KIND_EOF;
        end

        if (w_is_brk && !r_par) begin
            // line end at even parity
            if (r_mode != MODE_START) begin
                w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOF;
                w_cnt = w_cnt + TOK_CW'(1);
            end
            if (r_lhb) begin
                w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOR;
                w_cnt = w_cnt + TOK_CW'(1);
            end
            n_mode = MODE_START;
            n_par  = 1'b0;
            n_lhb  = 1'b0;
        end else begin
            n_lhb = 1'b1;
            if (w_is_quote) begin
                n_par = ~r_par;
            end
            unique case (r_mode)
                MODE_START: begin
                    if (w_byte == w_delim) begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOF;
                        w_cnt = w_cnt + TOK_CW'(1);
                    end else if (w_is_quote) begin
                        n_mode = MODE_QUOTED;
                    end else begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_BYTE;
                        w_cnt  = w_cnt + TOK_CW'(1);
                        n_mode = MODE_PLAIN;
                    end
                end
                MODE_PLAIN: begin
                    if (w_byte == w_delim) begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOF;
                        w_cnt  = w_cnt + TOK_CW'(1);
                        n_mode = MODE_START;
                    end else begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_BYTE;
                        w_cnt = w_cnt + TOK_CW'(1);
                    end
                end
                MODE_QUOTED: begin
                    if (w_is_quote) begin
                        n_mode = MODE_QSEEN;
                    end else begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_BYTE;
                        w_cnt = w_cnt + TOK_CW'(1);
                    end
                end
                MODE_QSEEN: begin
                    if (w_is_quote) begin
                        // doubled quote stands for one quote byte
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_BYTE;
                        w_cnt  = w_cnt + TOK_CW'(1);
                        n_mode = MODE_QUOTED;
                    end else begin
                        w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOF;
                        w_cnt = w_cnt + TOK_CW'(1);
                        if (w_byte == w_delim) begin
                            n_mode = MODE_START;
                        end else begin
                            w_kinds[w_cnt[TOK_IW-1:0]] = KIND_BYTE;
                            w_cnt  = w_cnt + TOK_CW'(1);
                            n_mode = MODE_PLAIN;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_START;
                end
            endcase
        end

        // flush at end of data
        if (i_in.end_of_data) begin
            if (n_mode != MODE_START) begin
                w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOF;
                w_cnt = w_cnt + TOK_CW'(1);
            end
            if (n_lhb) begin
                w_kinds[w_cnt[TOK_IW-1:0]] = KIND_EOR;
                w_cnt = w_cnt + TOK_CW'(1);
            end
            n_mode = MODE_START;
            n_par  = 1'b0;
            n_lhb  = 1'b0;
        end
    end

    assign w_accept    = i_in.valid && i_q_ready;
    assign i_in.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign w_last      = w_cnt - TOK_CW'(1);

    // push to the queue only when the byte causes beats
    assign o_push.valid          = w_accept && (w_cnt != '0);
    assign o_push.work.last_idx  = w_last[TOK_IW-1:0];
    assign o_push.work.kinds     = w_kinds;
    assign o_push.work.value     = w_byte;

    // parse state and delimiter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= CH_COMMA;
            r_mode  <= MODE_START;
            r_par   <= 1'b0;
            r_lhb   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_delim <= i_cfg.delimiter;
            end
            if (w_accept) begin
                r_mode <= n_mode;
                r_par  <= n_par;
                r_lhb  <= n_lhb;
            end
        end
    end

endmodule

/* rtl/core/csvt_queue.sv */
// ---------------------------------------------------------------------------
// csvt_queue
// short queue of classified bytes between front and back
// ---------------------------------------------------------------------------
module csvt_queue import csvt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_ready,
    output t_head o_head,
    input  logic  i_pop
);

    t_work           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            w_do_pop;

    assign o_ready     = (r_count != Q_CW'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.work  = r_mem[r_rd_ptr];
    assign w_do_pop     = i_pop && o_head.valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.work;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push.valid && !w_do_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (!i_push.valid && w_do_pop) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

endmodule

/* rtl/core/csvt_back.sv */
// ---------------------------------------------------------------------------
// csvt_back
// expands the queue head into result beats, one per cycle while the
// receiver is ready, into an output register
// ---------------------------------------------------------------------------
module csvt_back import csvt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_head         i_head,
    output logic          o_pop,
    csvt_out_if.source    o_out
);

    logic [TOK_IW-1:0] r_idx;
    logic              r_valid;
    t_kind             r_kind;
    logic [7:0]        r_value;
    logic              r_last;

    t_kind             w_kind;
    logic              w_load;
    logic              w_is_last;

    assign w_kind    = i_head.work.kinds[r_idx];
    assign w_is_last = (r_idx == i_head.work.last_idx);
    assign w_load    = i_head.valid && (!r_valid || o_out.ready);
    assign o_pop     = w_load && w_is_last;

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind  <= w_kind;
            r_value <= (w_kind == KIND_BYTE) ? i_head.work.value : 8'd0;
            r_last  <= w_is_last;
        end
    end

    // beat index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_is_last ? '0 : r_idx + TOK_IW'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.value       = r_value;
    assign o_out.last_of_run = r_last;

endmodule

/* rtl/core/csv_field_tokenizer.sv */
// ---------------------------------------------------------------------------
// csv_field_tokenizer
// streaming csv tokenizer: field bytes, end-of-field and end-of-row beats
// ---------------------------------------------------------------------------
// The block takes one document byte per cycle while its four-entry queue
// has room, and each byte causes zero to four result beats, the last one
// flagged by last_of_run. The output register drains one beat per cycle
// while the receiver is ready, and a byte's queue entry is freed when its
// last beat loads; sustained rate is set by the output side. A beat passes
// through a queue entry and then the output register. The delimiter
// register resets to comma and may be written whenever the block is idle.
module csv_field_tokenizer import csvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csvt_in_if.sink     i_in,
    csvt_cfg_if.sink    i_cfg,
    csvt_out_if.source  o_out
);

    t_push w_push;
    t_head w_head;
    logic  w_q_ready;
    logic  w_pop;

    // classify incoming bytes
    csvt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push)
    );

    // decouple front and back
    csvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // emit result beats
    csvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/csvt_checker.sv */
// ---------------------------------------------------------------------------
// csvt_checker
// port-level assertions on the tokenizer output channel
// ---------------------------------------------------------------------------
`include "csv_field_tokenizer_macros.svh"

module csvt_checker import csvt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_value,
    input logic       i_out_last
);

    // a stalled beat stays offered
    `CSVT_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "output beat dropped while stalled")

    // marks carry a zero value
    `CSVT_ASSERT(a_mark_zero, i_out_valid && (i_out_kind == KIND_EOF || i_out_kind == KIND_EOR) |-> i_out_value == 8'd0, "mark beat with nonzero value")

    // end of row always closes a byte's run
    `CSVT_ASSERT(a_eor_last, i_out_valid && i_out_kind == KIND_EOR |-> i_out_last, "end of row not last of run")

    // nothing offered while in reset
    `CSVT_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last_of_run)
);

/* dv/csvt_token_checker.sv */
// ---------------------------------------------------------------------------
// csvt_token_checker
// watches the byte, result and delimiter channels of the csv tokenizer,
// works out the result beats each accepted byte should cause and compares
// every result beat, in order, with the oldest one still owed
// ---------------------------------------------------------------------------
module csvt_token_checker import csvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    input  logic       i_last_of_run,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_delimiter,
    output int         o_err_count,
    output int         o_pending
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_tok;

    // beats still owed by the block, oldest first
    t_tok owed_q[$];
    t_tok head;
    int   errs;

    // tokenizer state as the block should hold it
    logic [7:0] delim;
    t_mode      mode;
    logic       parity;
    logic       line_open;

    // beats caused by the byte being worked on
    t_kind      beat_kind [TOK_MAX];
    logic [7:0] beat_val  [TOK_MAX];
    int         beat_n;

    function automatic void add_beat(input t_kind k, input logic [7:0] v);
        if (beat_n < TOK_MAX) begin
            beat_kind[beat_n] = k;
            beat_val[beat_n]  = v;
            beat_n++;
        end
    endfunction

    // line end or end of data: close open field, then a non-empty row
    function automatic void end_line();
        if (mode != MODE_START)
            add_beat(KIND_EOF, 8'h00);
        if (line_open)
            add_beat(KIND_EOR, 8'h00);
        mode      = MODE_START;
        parity    = 1'b0;
        line_open = 1'b0;
    endfunction

    function automatic void tokenize(input logic [7:0] b, input logic eod);
        logic [7:0] sep;
        t_tok       t;
        // zero, quote, cr and lf cannot separate fields, comma stands in
        sep = (delim == CH_QUOTE || delim == CH_CR || delim == CH_LF || delim == 8'h00)
            ? CH_COMMA : delim;
        beat_n = 0;
        if ((b == CH_CR || b == CH_LF) && !parity) begin
            end_line();
        end else begin
            line_open = 1'b1;
            if (b == CH_QUOTE)
                parity = ~parity;
            case (mode)
                MODE_START: begin
                    if (b == sep) begin
                        add_beat(KIND_EOF, 8'h00);
                    end else if (b == CH_QUOTE) begin
                        mode = MODE_QUOTED;
                    end else begin
                        add_beat(KIND_BYTE, b);
                        mode = MODE_PLAIN;
                    end
                end
                MODE_PLAIN: begin
                    if (b == sep) begin
                        add_beat(KIND_EOF, 8'h00);
                        mode = MODE_START;
                    end else begin
                        add_beat(KIND_BYTE, b);
                    end
                end
                MODE_QUOTED: begin
                    if (b == CH_QUOTE)
                        mode = MODE_QSEEN;
                    else
                        add_beat(KIND_BYTE, b);
                end
                default: begin
                    // doubled quote gives one quote, anything else closes the field
                    if (b == CH_QUOTE) begin
                        add_beat(KIND_BYTE, CH_QUOTE);
                        mode = MODE_QUOTED;
                    end else begin
                        add_beat(KIND_EOF, 8'h00);
                        if (b == sep) begin
                            mode = MODE_START;
                        end else begin
                            add_beat(KIND_BYTE, b);
                            mode = MODE_PLAIN;
                        end
                    end
                end
            endcase
        end
        if (eod)
            end_line();
        for (int i = 0; i < beat_n; i++) begin
            t.kind  = beat_kind[i];
            t.value = beat_val[i];
            t.last  = (i == beat_n - 1);
            owed_q.push_back(t);
        end
    endfunction

    // sample every channel at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_q.delete();
            errs        = 0;
            delim       = CH_COMMA;
            mode        = MODE_START;
            parity      = 1'b0;
            line_open   = 1'b0;
            o_err_count <= 0;
            o_pending   <= 0;
        end else begin
            // result beat against the oldest owed one
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected beat: expected none, actual kind=%0d value=%02h last=%0b",
                             $time, i_kind, i_value, i_last_of_run);
                end else begin
                    head = owed_q.pop_front();
                    if (head.kind !== i_kind || head.value !== i_value ||
                        head.last !== i_last_of_run) begin
                        errs++;
                        $display("%0t: beat mismatch: expected kind=%0d value=%02h last=%0b, actual kind=%0d value=%02h last=%0b",
                                 $time, head.kind, head.value, head.last,
                                 i_kind, i_value, i_last_of_run);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize(i_data_byte, i_end_of_data);
            if (i_cfg_valid && i_cfg_ready)
                delim = i_cfg_delimiter;
            o_err_count <= errs;
            o_pending   <= owed_q.size();
        end
    end

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// drives csv documents into the tokenizer under random sender gaps and
// receiver stalls, across several delimiter settings, and reports the
// verdict from the token checker
// ---------------------------------------------------------------------------
module tb;
    import csvt_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENT_BYTES = 36;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_SEGMENTS    = 8;

    logic i_clk;
    logic i_rst_n;

    int send_gap_pct;
    int recv_stall_pct;
    int sent_count;
    int stall_cycles = 0;
    int chk_errs;
    int chk_pending;

    // delimiter settings, extremes and unusable ones among them
    logic [7:0] delim_list [N_SEGMENTS] = '{CH_COMMA, 8'h3B, 8'h01, CH_QUOTE,
                                            8'hFF, CH_CR, 8'h09, CH_LF};

    csvt_in_if  in_ch();
    csvt_out_if out_ch();
    csvt_cfg_if cfg_ch();

    csv_field_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    csvt_token_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_data_byte     (in_ch.data_byte),
        .i_end_of_data   (in_ch.end_of_data),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_kind          (out_ch.kind),
        .i_value         (out_ch.value),
        .i_last_of_run   (out_ch.last_of_run),
        .i_cfg_valid     (cfg_ch.valid),
        .i_cfg_ready     (cfg_ch.ready),
        .i_cfg_delimiter (cfg_ch.delimiter),
        .o_err_count     (chk_errs),
        .o_pending       (chk_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no beat moving on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic rare_eod();
        return ($urandom_range(99) < 2);
    endfunction

    // content byte for a plain or quoted field
    function automatic logic [7:0] plain_char(input logic [7:0] d);
        logic [7:0] c;
        do c = $urandom_range(255, 1);
        while (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == CH_COMMA || c == d);
        return c;
    endfunction

    // one byte beat, after a random gap
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_data <= eod;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // hold the sender until every owed beat is out and the block has settled
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delimiter(input logic [7:0] d);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.delimiter <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // well-formed row: plain and quoted fields, doubled quotes, cr lf or lf
    task automatic send_record(input logic [7:0] sep);
        int nf;
        int len;
        nf = $urandom_range(4, 1);
        for (int f = 0; f < nf; f++) begin
            if (f > 0)
                send_byte(sep, rare_eod());
            len = $urandom_range(4, 0);
            if ($urandom_range(99) < 40) begin
                send_byte(CH_QUOTE, rare_eod());
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 15) begin
                        send_byte(CH_QUOTE, 1'b0);
                        send_byte(CH_QUOTE, rare_eod());
                    end else begin
                        send_byte(plain_char(CH_QUOTE) | (($urandom_range(9) == 0) ?
                                  8'h00 : 8'h00), rare_eod());
                    end
                end
                send_byte(CH_QUOTE, rare_eod());
            end else begin
                for (int i = 0; i < len; i++)
                    send_byte(plain_char(sep), rare_eod());
            end
        end
        if ($urandom_range(1))
            send_byte(CH_CR, rare_eod());
        send_byte(CH_LF, rare_eod());
    endtask

    // loose byte: raw delimiter, quote, line break or anything
    task automatic send_noise(input logic [7:0] d);
        int r;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 25)
            b = d;
        else if (r < 45)
            b = CH_QUOTE;
        else if (r < 60)
            b = $urandom_range(1) ? CH_CR : CH_LF;
        else
            b = $urandom_range(255, 1);
        send_byte(b, ($urandom_range(99) < 4));
    endtask

    initial begin
        logic [7:0] sep;
        int seg_start;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'h00;
        in_ch.end_of_data  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.delimiter   <= 8'h00;
        sent_count         = 0;
        send_gap_pct       = 38;
        recv_stall_pct     = 63;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset delimiter
        // empty field and trailing delimiter
        send_text("a,,\n");
        // quoted field with a doubled quote
        send_text("\"x\"\"\",");
        // bytes after a closing quote, then a cr lf pair
        send_text("\"q\"z\r\n");
        // line break at odd quote count outside quotes stays a byte
        send_text("p\"\n\"\r");
        // unterminated quoted field closed by end of data, byte extremes
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        // closing quote, new field and end of data: four beats
        send_text("\"v\"");
        send_byte(8'h77, 1'b1);
        wait_idle();

        // random documents, one delimiter setting per segment
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            if (seg < 3) begin
                send_gap_pct   = 38;
                recv_stall_pct = 63;
            end else if (seg < 6) begin
                send_gap_pct   = 63;
                recv_stall_pct = 38;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_delimiter(delim_list[seg]);
            sep = delim_list[seg];
            if (sep == CH_QUOTE || sep == CH_CR || sep == CH_LF)
                sep = CH_COMMA;
            seg_start = sent_count;
            while (sent_count - seg_start < SEGMENT_BYTES) begin
                if ($urandom_range(99) < 80)
                    send_record(sep);
                else
                    send_noise(delim_list[seg]);
            end
            wait_idle();
        end

        if (chk_errs == 0 && chk_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/csvt_pkg.sv
rtl/core/csvt_ifs.sv
rtl/core/csvt_front.sv
rtl/core/csvt_queue.sv
rtl/core/csvt_back.sv
rtl/core/csv_field_tokenizer.sv
rtl/core/csvt_checker.sv
dv/csvt_token_checker.sv
dv/tb.sv
